// ----- hw/rtl/pbsm_pkg.sv -----
package pbsm_pkg;
	localparam int MAX_WIDTH_D   = 320;
	localparam int MAX_HEIGHT_D  = 240;
	localparam int MAX_SAMPLES_D = 16;
	localparam int PIX_W         = 24;
	localparam int CFG_IDX_W     = 3;
	localparam int CFG_DATA_W    = 9;
	localparam int DIST_SCALE    = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WIDTH     = 3'd0,
		REG_HEIGHT    = 3'd1,
		REG_THREE_CH  = 3'd2,
		REG_SAMPLES   = 3'd3,
		REG_MATCHES   = 3'd4,
		REG_THRESHOLD = 3'd5,
		REG_COLOR_OUT = 3'd6
	} reg_idx_t;

	localparam logic OP_INIT     = 1'b0;
	localparam logic OP_CLASSIFY = 1'b1;

	typedef struct packed {
		logic [8:0] frame_width;
		logic [7:0] frame_height;
		logic       three_channels;
		logic [4:0] sample_count;
		logic [4:0] match_count;
		logic [7:0] dist_threshold;
		logic       color_output;
	} cfg_t;

	typedef struct packed {
		logic       op;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       self_update;
		logic [3:0] self_slot;
		logic       neighbor_update;
		logic [3:0] neighbor_slot;
		logic [1:0] neighbor_dx;
		logic [1:0] neighbor_dy;
	} pix_in_t;

	typedef struct packed {
		logic       foreground;
		logic [7:0] out_red;
		logic [7:0] out_green;
		logic [7:0] out_blue;
		logic       frame_end;
	} pix_out_t;

	function automatic logic [7:0] absdiff8(logic [7:0] a, logic [7:0] b);
		return (a > b) ? a - b : b - a;
	endfunction
endpackage

// ----- hw/rtl/pbsm_if.sv -----
interface pbsm_in_if;
	import pbsm_pkg::*;
	logic    valid;
	logic    ready;
	pix_in_t data;
	modport source(output valid, data, input ready);
	modport sink(input valid, data, output ready);
endinterface

interface pbsm_out_if;
	import pbsm_pkg::*;
	logic     valid;
	logic     ready;
	pix_out_t data;
	modport source(output valid, data, input ready);
	modport sink(input valid, data, output ready);
endinterface

interface pbsm_cfg_if;
	import pbsm_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] wdata;
	modport source(output valid, index, wdata, input ready);
	modport sink(input valid, index, wdata, output ready);
endinterface

// ----- hw/rtl/pixel_background_sample_model.sv -----
// channel | dir | payload
// cfg     | in  | index, wdata (register write)
// pix_in  | in  | op, pixel bytes, update hits, slots, neighbor offset
// pix_out | out | foreground, out bytes, frame_end (classify only)
// Init item: accepted, then written in ST_WR_NB. Classify: ST_READ reads one
// sample per cycle from the sample RAM, each passing the RAM output and match
// registers; ST_WAIT drains them, ST_DONE gives the result and a background
// pixel adds ST_WR_SELF and ST_WR_NB write-backs. Reset clears control and
// position; sample RAM is not cleared. Output is held in a register until taken;
// the next item is accepted meanwhile and a classify waits in ST_DONE while full.
module pixel_background_sample_model
	import pbsm_pkg::*;
#(
	parameter int MAX_WIDTH   = MAX_WIDTH_D,
	parameter int MAX_HEIGHT  = MAX_HEIGHT_D,
	parameter int MAX_SAMPLES = MAX_SAMPLES_D
) (
	input  logic       clk,
	input  logic       arst_n,
	pbsm_cfg_if.sink   cfg,
	pbsm_in_if.sink    pix_in,
	pbsm_out_if.source pix_out
);
	localparam int XW = $clog2(MAX_WIDTH);
	localparam int YW = $clog2(MAX_HEIGHT);
	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT * MAX_SAMPLES;
	localparam int AW = $clog2(DEPTH);
	localparam int PW = $clog2(MAX_WIDTH * MAX_HEIGHT);

	typedef enum logic [2:0] {ST_IDLE, ST_READ, ST_WAIT, ST_DONE, ST_WR_SELF,
		ST_WR_NB} state_t;

	cfg_t     cfg_q;
	state_t   state_q;
	pix_in_t  item_q;
	logic [9:0]  col_q;
	logic [8:0]  row_q;
	logic [XW-1:0] x_q, nx_q;
	logic [YW-1:0] y_q, ny_q;
	logic        last_q;
	logic [5:0]  idx_q;
	logic [5:0]  count_q;
	logic        out_valid_q;
	pix_out_t    out_q;
	logic [17:0] limit_q;

	logic [12:0] w_eff, h_eff;
	logic [6:0]  n_eff;
	logic [9:0]  col_c;
	logic [8:0]  row_c;
	logic        accept;
	logic        out_free;
	logic        we;
	logic [AW-1:0] waddr, raddr;
	logic [23:0] rdata;
	logic        close_s1;
	logic        rd_valid_s1, rd_valid_s2;

	always_comb begin
		w_eff = (cfg_q.frame_width == 0) ? 13'd1 :
			(13'(cfg_q.frame_width) > 13'(MAX_WIDTH)) ? 13'(MAX_WIDTH) : 13'(cfg_q.frame_width);
		h_eff = (cfg_q.frame_height == 0) ? 13'd1 :
			(13'(cfg_q.frame_height) > 13'(MAX_HEIGHT)) ? 13'(MAX_HEIGHT) :
			13'(cfg_q.frame_height);
		n_eff = (7'(cfg_q.sample_count) > 7'(MAX_SAMPLES)) ? 7'(MAX_SAMPLES) :
			7'(cfg_q.sample_count);
		col_c = col_q;
		row_c = row_q;
		if (13'(col_c) >= w_eff) begin
			col_c = '0;
			row_c = row_q + 9'd1;
		end
		if (13'(row_c) >= h_eff) begin
			row_c = '0;
		end
	end

	assign accept       = pix_in.valid && pix_in.ready;
	assign pix_in.ready = (state_q == ST_IDLE);
	assign out_free     = !out_valid_q || pix_out.ready;
	assign cfg.ready    = 1'b1;
	assign pix_out.valid = out_valid_q;
	assign pix_out.data  = out_q;

	function automatic logic [12:0] clampo(logic [12:0] p, logic [1:0] o, logic [12:0] lim);
		if (o == 2'b01) begin
			return (p + 13'd1 < lim) ? p + 13'd1 : lim - 13'd1;
		end else if (o == 2'b00) begin
			return p;
		end
		return (p > 0) ? p - 13'd1 : 13'd0;
	endfunction

	function automatic logic [AW-1:0] addr(logic [XW-1:0] x, logic [YW-1:0] y,
		logic [3:0] s);
		return AW'((PW'(y) * PW'(MAX_WIDTH) + PW'(x)) * AW'(MAX_SAMPLES) + AW'(s));
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{frame_width: 9'd320, frame_height: 8'd240, three_channels: 1'b1,
				sample_count: 5'd16, match_count: 5'd2, dist_threshold: 8'd20,
				color_output: 1'b1};
		end else if (cfg.valid) begin
			case (reg_idx_t'(cfg.index))
				REG_WIDTH:     cfg_q.frame_width     <= cfg.wdata;
				REG_HEIGHT:    cfg_q.frame_height    <= cfg.wdata[7:0];
				REG_THREE_CH:  cfg_q.three_channels  <= cfg.wdata[0];
				REG_SAMPLES:   cfg_q.sample_count    <= cfg.wdata[4:0];
				REG_MATCHES:   cfg_q.match_count     <= cfg.wdata[4:0];
				REG_THRESHOLD: cfg_q.dist_threshold  <= cfg.wdata[7:0];
				REG_COLOR_OUT: cfg_q.color_output    <= cfg.wdata[0];
				default: ;
			endcase
		end
	end

	logic fg_c;
	assign fg_c = {1'b0, count_q} < {2'b0, cfg_q.match_count};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			col_q       <= '0;
			row_q       <= '0;
			out_valid_q <= 1'b0;
			rd_valid_s1 <= 1'b0;
			rd_valid_s2 <= 1'b0;
		end else begin
			// in ST_DONE the result register is refilled in the same cycle
			if (pix_out.valid && pix_out.ready && state_q != ST_DONE) begin
				out_valid_q <= 1'b0;
			end
			rd_valid_s1 <= 1'b0;
			rd_valid_s2 <= rd_valid_s1;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						item_q  <= pix_in.data;
						x_q     <= XW'(col_c);
						y_q     <= YW'(row_c);
						nx_q    <= XW'(clampo(13'(col_c), pix_in.data.neighbor_dx, w_eff));
						ny_q    <= YW'(clampo(13'(row_c), pix_in.data.neighbor_dy, h_eff));
						last_q  <= (13'(col_c) == w_eff - 13'd1) && (13'(row_c) == h_eff - 13'd1);
						limit_q <= 18'(DIST_SCALE) * 18'(cfg_q.dist_threshold) *
							18'(cfg_q.dist_threshold);
						idx_q   <= '0;
						count_q <= '0;
						if (13'(col_c) + 13'd1 >= w_eff) begin
							col_q <= '0;
							row_q <= (13'(row_c) + 13'd1 >= h_eff) ? '0 : row_c + 9'd1;
						end else begin
							col_q <= col_c + 10'd1;
							row_q <= row_c;
						end
						state_q <= (pix_in.data.op == OP_CLASSIFY) ? ST_READ : ST_WR_NB;
					end
				end
				ST_READ: begin
					// one sample read per cycle; each result passes the RAM and match registers
					if (7'(idx_q) < n_eff) begin
						rd_valid_s1 <= 1'b1;
						idx_q <= idx_q + 6'd1;
					end else begin
						state_q <= ST_WAIT;
					end
				end
				ST_WAIT: begin
					if (!rd_valid_s1 && !rd_valid_s2) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						out_valid_q        <= 1'b1;
						out_q.foreground   <= fg_c;
						out_q.frame_end    <= last_q;
						out_q.out_red      <= !fg_c ? 8'd0 : cfg_q.color_output ? item_q.red : 8'hFF;
						out_q.out_green    <= (fg_c && cfg_q.color_output && cfg_q.three_channels) ?
							item_q.green : 8'd0;
						out_q.out_blue     <= (fg_c && cfg_q.color_output && cfg_q.three_channels) ?
							item_q.blue : 8'd0;
						state_q <= fg_c ? ST_IDLE : ST_WR_SELF;
					end
				end
				ST_WR_SELF: state_q <= ST_WR_NB;
				ST_WR_NB:   state_q <= ST_IDLE;
				default:    state_q <= ST_IDLE;
			endcase
			// early stop once enough matches counted is equivalent to full count
			if (rd_valid_s2 && close_s1 && fg_c) begin
				count_q <= count_q + 6'd1;
			end
		end
	end

	logic        do_self, do_nb;
	logic [23:0] pix;
	assign pix     = {item_q.blue, item_q.green, item_q.red};
	assign do_self = (state_q == ST_WR_SELF) && item_q.self_update &&
		(7'(item_q.self_slot) < n_eff);
	assign do_nb   = (state_q == ST_WR_NB) && (7'(item_q.op == OP_INIT ? item_q.self_slot :
		item_q.neighbor_slot) < n_eff) && (item_q.op == OP_INIT || item_q.neighbor_update);
	assign we      = do_self || do_nb;
	assign waddr   = do_self ? addr(x_q, y_q, item_q.self_slot) :
		addr(nx_q, ny_q, item_q.op == OP_INIT ? item_q.self_slot : item_q.neighbor_slot);
	assign raddr   = addr(x_q, y_q, idx_q[3:0]);

	pbsm_ram #(.WIDTH(PIX_W), .DEPTH(DEPTH)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(pix), .raddr(raddr), .rdata(rdata)
	);

	pbsm_match u_match (
		.clk(clk), .red(item_q.red), .green(item_q.green), .blue(item_q.blue),
		.sample(rdata), .color_dist(cfg_q.three_channels && cfg_q.color_output),
		.threshold(cfg_q.dist_threshold), .limit(limit_q), .close_s1(close_s1)
	);

	assert property (@(posedge clk) disable iff (!arst_n)
		we |-> (state_q == ST_WR_SELF || state_q == ST_WR_NB)) else $error("stray write");
	assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> state_q == ST_IDLE) else $error("accept while busy");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE) |=> out_valid_q) else $error("result lost");
	assert property (@(posedge clk) disable iff (!arst_n)
		rd_valid_s1 |-> state_q == ST_READ || state_q == ST_WAIT) else $error("read late");
endmodule

// ----- hw/rtl/pbsm_ram.sv -----
module pbsm_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ----- hw/rtl/pbsm_match.sv -----
// Per-sample closeness test, registered.
module pbsm_match (
	input  logic             clk,
	input  logic [7:0]       red,
	input  logic [7:0]       green,
	input  logic [7:0]       blue,
	input  logic [23:0]      sample,
	input  logic             color_dist,
	input  logic [7:0]       threshold,
	input  logic [17:0]      limit,
	output logic             close_s1
);
	import pbsm_pkg::*;
	logic [7:0]  dr, dg, db;
	logic [17:0] sum;

	always_comb begin
		dr  = absdiff8(red, sample[7:0]);
		dg  = absdiff8(green, sample[15:8]);
		db  = absdiff8(blue, sample[23:16]);
		sum = 18'(16'(dr) * 16'(dr)) + 18'(16'(dg) * 16'(dg)) + 18'(16'(db) * 16'(db));
	end

	always_ff @(posedge clk) begin
		close_s1 <= color_dist ? (sum < limit) : (dr < threshold);
	end
endmodule
